### hw/rtl/hsl_pkg.sv
// Shared types and constants for the HSL to RGBA converter.
`default_nettype none

package hsl_pkg;

  localparam int unsigned HueW    = 15;
  localparam int unsigned UnitW   = 11;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WeightW = 12;

  localparam logic [HueW-1:0]  HueFull    = 15'd23040;
  localparam logic [HueW-1:0]  SectorSpan = 15'd3840;
  localparam logic [UnitW-1:0] UnitOne    = 11'd1024;

  // Reciprocal of 15 scaled by 2^20, rounded up; exact for dividends below 2^14.
  localparam logic [16:0] RecipFifteen = 17'd69906;
  localparam int unsigned RecipShift   = 20;

  localparam logic [1:0] CfgSaturation = 2'd0;
  localparam logic [1:0] CfgLuminance  = 2'd1;
  localparam logic [1:0] CfgAlpha      = 2'd2;

  typedef enum logic [2:0] {
    SecRedYellow,
    SecYellowGreen,
    SecGreenCyan,
    SecCyanBlue,
    SecBlueMagenta,
    SecMagentaRed
  } sector_e;

  typedef struct packed {
    sector_e              sector;
    logic [WeightW-1:0]   weight;
  } work_t;

  typedef struct packed {
    logic [UnitW-1:0] chroma;
    logic [UnitW-1:0] offset;
    logic [ByteW-1:0] alpha_byte;
  } color_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

### hw/rtl/hsl_to_rgba_converter_top.sv
// Top level of the HSL to RGBA converter: front end, queue, back end and configuration.
//
// A hue beat on the input channel (hue_position_i, 1/64 degree) gives one RGBA beat on
// the output channel. Saturation, luminance and alpha come from configuration registers
// 0, 1 and 2 (1/1024 units, values above 1024 act as 1024); writes to index 3 are dropped.
// The configuration channel is always ready and should be written while no beat is in
// flight; the derived chroma and offset terms are registered, the offset after the chroma.
// A beat passes through the front register, the queue, the back end stages and the
// output register. Throughput is one beat per cycle while the receiver stays ready;
// each back end multiplier sits in its own pipelined stage. Hues of 23040 and above
// wrap around. When the receiver stalls, the back end holds its stages, the queue fills
// and the front end then drops in_ready_o; no beat is lost. Reset empties all stages and
// the queue and restores saturation 1024, luminance 512 and alpha 1024.
`default_nettype none

module hsl_to_rgba_converter_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [hsl_pkg::HueW-1:0]  hue_position_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [hsl_pkg::ByteW-1:0]      red_o,
  output logic [hsl_pkg::ByteW-1:0]      green_o,
  output logic [hsl_pkg::ByteW-1:0]      blue_o,
  output logic [hsl_pkg::ByteW-1:0]      alpha_out_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [hsl_pkg::UnitW-1:0] cfg_data_i
);

  logic                 push, pop;
  hsl_pkg::work_t       wdata, rdata;
  hsl_pkg::queue_stat_t stat;
  hsl_pkg::color_t      color;

  assign cfg_ready_o = 1'b1;

  hsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .color_o     (color)
  );

  hsl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .hue_position_i (hue_position_i),
    .push_o         (push),
    .work_o         (wdata),
    .stat_i         (stat)
  );

  hsl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .stat_o  (stat)
  );

  hsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .work_i      (rdata),
    .pop_o       (pop),
    .color_i     (color),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_out_o (alpha_out_o)
  );

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("Queue reports full and empty together.");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !pop)
    else $error("Queue popped while the output beat is stalled.");

  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stat.full)
    else $error("Input held off while the queue has room.");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.full && !pop) |=> !(stat.empty))
    else $error("Full queue drained without a pop.");

endmodule

`default_nettype wire

### hw/rtl/hsl_cfg.sv
// Configuration registers and the chroma, offset and alpha terms derived from them.
`default_nettype none

module hsl_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [hsl_pkg::UnitW-1:0] cfg_data_i,
  output hsl_pkg::color_t                color_o
);

  logic [hsl_pkg::UnitW-1:0] sat_q, lum_q, alp_q;
  logic [hsl_pkg::UnitW-1:0] sat_c, lum_c, alp_c;
  logic [hsl_pkg::UnitW:0]   twol, lum_dist;
  logic [hsl_pkg::UnitW-1:0] span;
  logic [21:0]               cprod;
  logic [18:0]               aprod;
  logic [hsl_pkg::UnitW-1:0] c_q, l_q, m_q;
  logic [hsl_pkg::ByteW-1:0] a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= hsl_pkg::UnitOne;
      lum_q <= 11'd512;
      alp_q <= hsl_pkg::UnitOne;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hsl_pkg::CfgSaturation: sat_q <= cfg_data_i;
        hsl_pkg::CfgLuminance:  lum_q <= cfg_data_i;
        hsl_pkg::CfgAlpha:      alp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sat_c    = (sat_q > hsl_pkg::UnitOne) ? hsl_pkg::UnitOne : sat_q;
    lum_c    = (lum_q > hsl_pkg::UnitOne) ? hsl_pkg::UnitOne : lum_q;
    alp_c    = (alp_q > hsl_pkg::UnitOne) ? hsl_pkg::UnitOne : alp_q;
    twol     = {lum_c, 1'b0};
    lum_dist = (twol >= {1'b0, hsl_pkg::UnitOne}) ? twol - {1'b0, hsl_pkg::UnitOne}
                                                  : {1'b0, hsl_pkg::UnitOne} - twol;
    span     = hsl_pkg::UnitW'({1'b0, hsl_pkg::UnitOne} - lum_dist);
    cprod    = 22'(span) * 22'(sat_c);
    aprod    = ({8'd0, alp_c} << 8) - {8'd0, alp_c};
  end

  // Chroma is registered from the stored settings, and the offset settles in the cycle after the chroma.
  always_ff @(posedge clk_i) begin
    c_q <= cprod[20:10];
    l_q <= lum_c;
    m_q <= l_q - {1'b0, c_q[hsl_pkg::UnitW-1:1]};
    a_q <= aprod[17:10];
  end

  assign color_o.chroma     = c_q;
  assign color_o.offset     = m_q;
  assign color_o.alpha_byte = a_q;

endmodule

`default_nettype wire

### hw/rtl/hsl_front.sv
// Front end: takes a hue beat, wraps it onto the circle and finds its sector and weight.
`default_nettype none

module hsl_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [hsl_pkg::HueW-1:0] hue_position_i,
  output logic                          push_o,
  output hsl_pkg::work_t                work_o,
  input  wire hsl_pkg::queue_stat_t     stat_i
);

  logic                     fv_q, fv_d;
  logic [hsl_pkg::HueW-1:0] h_q, h_wrap;
  logic [1:0]               pair;
  logic [hsl_pkg::HueW-1:0] hm, hd;
  logic                     odd;

  assign push_o     = fv_q & ~stat_i.full;
  assign in_ready_o = ~fv_q | push_o;
  assign h_wrap     = (hue_position_i >= hsl_pkg::HueFull) ?
                      hue_position_i - hsl_pkg::HueFull : hue_position_i;

  always_comb begin
    fv_d = fv_q;
    if (in_valid_i && in_ready_o) begin
      fv_d = 1'b1;
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      h_q <= h_wrap;
    end
  end

  always_comb begin
    if (h_q >= 15'd15360) begin
      pair = 2'd2;
      hm   = h_q - 15'd15360;
    end else if (h_q >= 15'd7680) begin
      pair = 2'd1;
      hm   = h_q - 15'd7680;
    end else begin
      pair = 2'd0;
      hm   = h_q;
    end
    odd = (hm >= hsl_pkg::SectorSpan);
    hd  = odd ? hm - hsl_pkg::SectorSpan : hsl_pkg::SectorSpan - hm;
    work_o.weight = hsl_pkg::WeightW'(hsl_pkg::SectorSpan - hd);
    work_o.sector = hsl_pkg::sector_e'({pair, odd});
  end

endmodule

`default_nettype wire

### hw/rtl/hsl_fifo.sv
// Short queue that decouples the front end from the arithmetic back end.
`default_nettype none

module hsl_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire hsl_pkg::work_t       wdata_i,
  input  wire logic                 pop_i,
  output hsl_pkg::work_t            rdata_o,
  output hsl_pkg::queue_stat_t      stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsl_pkg::work_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hsl_back.sv
// Back end: scales chroma by the sector weight, places the channels and converts to bytes.
`default_nettype none

module hsl_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hsl_pkg::queue_stat_t      stat_i,
  input  wire hsl_pkg::work_t            work_i,
  output logic                           pop_o,
  input  wire hsl_pkg::color_t           color_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [hsl_pkg::ByteW-1:0]      red_o,
  output logic [hsl_pkg::ByteW-1:0]      green_o,
  output logic [hsl_pkg::ByteW-1:0]      blue_o,
  output logic [hsl_pkg::ByteW-1:0]      alpha_out_o
);

  logic                      adv;
  logic                      v1_q, v2_q, ov_q;
  hsl_pkg::sector_e          sec1_q, sec2_q;
  logic [13:0]               q1_q;
  logic [hsl_pkg::UnitW-1:0] x2_q;
  logic [22:0]               wprod;
  logic [30:0]               rprod;
  logic [hsl_pkg::UnitW-1:0] cr, cg, cb;
  logic [7:0]                rb, gb, bb;

  function automatic logic [7:0] to_byte(input logic [hsl_pkg::UnitW-1:0] comp,
                                         input logic [hsl_pkg::UnitW-1:0] offs);
    logic [11:0] v;
    logic [19:0] p;
    v = {1'b0, comp} + {1'b0, offs};
    p = ({8'd0, v} << 8) - {8'd0, v};
    to_byte = (p[19:10] > 10'd255) ? 8'd255 : p[17:10];
  endfunction

  assign adv         = ~ov_q | out_ready_i;
  assign pop_o       = adv & ~stat_i.empty;
  assign out_valid_o = ov_q;

  assign wprod = 23'(color_i.chroma) * 23'(work_i.weight);
  assign rprod = 31'(q1_q) * 31'(hsl_pkg::RecipFifteen);

  always_comb begin
    cr = '0;
    cg = '0;
    cb = '0;
    case (sec2_q)
      hsl_pkg::SecRedYellow:   begin cr = color_i.chroma; cg = x2_q; end
      hsl_pkg::SecYellowGreen: begin cr = x2_q; cg = color_i.chroma; end
      hsl_pkg::SecGreenCyan:   begin cg = color_i.chroma; cb = x2_q; end
      hsl_pkg::SecCyanBlue:    begin cg = x2_q; cb = color_i.chroma; end
      hsl_pkg::SecBlueMagenta: begin cr = x2_q; cb = color_i.chroma; end
      default:                 begin cr = color_i.chroma; cb = x2_q; end
    endcase
    rb = to_byte(cr, color_i.offset);
    gb = to_byte(cg, color_i.offset);
    bb = to_byte(cb, color_i.offset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      ov_q <= v2_q;
    end
  end

  // Division by 3840 is a right shift by eight bits followed by a reciprocal multiply for 15.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec1_q      <= work_i.sector;
      q1_q        <= wprod[21:8];
      sec2_q      <= sec1_q;
      x2_q        <= rprod[hsl_pkg::RecipShift +: hsl_pkg::UnitW];
      red_o       <= rb;
      green_o     <= gb;
      blue_o      <= bb;
      alpha_out_o <= color_i.alpha_byte;
    end
  end

endmodule

`default_nettype wire

### sim/hsl_to_rgba_converter_top_test.sv
// Self-checking testbench for the HSL to RGBA converter, with a scoreboard class.
module hsl_to_rgba_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [hsl_pkg::ByteW-1:0] red;
    logic [hsl_pkg::ByteW-1:0] green;
    logic [hsl_pkg::ByteW-1:0] blue;
    logic [hsl_pkg::ByteW-1:0] alpha;
  } pixel_t;

  class pixel_scoreboard;
    logic [hsl_pkg::UnitW-1:0] saturation_reg;
    logic [hsl_pkg::UnitW-1:0] luminance_reg;
    logic [hsl_pkg::UnitW-1:0] alpha_reg;
    pixel_t expected_pixels[$];
    int unsigned mismatches;

    function new();
      saturation_reg = hsl_pkg::UnitOne;
      luminance_reg = 11'd512;
      alpha_reg = hsl_pkg::UnitOne;
      mismatches = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [hsl_pkg::UnitW-1:0] value);
      case (index)
        hsl_pkg::CfgSaturation: saturation_reg = value;
        hsl_pkg::CfgLuminance: luminance_reg = value;
        hsl_pkg::CfgAlpha: alpha_reg = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function logic [hsl_pkg::ByteW-1:0] to_byte(int unsigned v);
      int unsigned q;
      q = (v * 255) / 32'(hsl_pkg::UnitOne);
      if (q > 255) q = 255;
      return q[hsl_pkg::ByteW-1:0];
    endfunction

    function pixel_t color_for_hue(logic [hsl_pkg::HueW-1:0] hue);
      int unsigned span, unit, h, s, l, a, twice_l, lum_dist, chroma;
      int unsigned hue_mod, hue_dist, second, offset, r, g, b;
      pixel_t px;
      span = 32'(hsl_pkg::SectorSpan);
      unit = 32'(hsl_pkg::UnitOne);
      h = 32'(hue) % 32'(hsl_pkg::HueFull);
      s = (32'(saturation_reg) > unit) ? unit : 32'(saturation_reg);
      l = (32'(luminance_reg) > unit) ? unit : 32'(luminance_reg);
      a = (32'(alpha_reg) > unit) ? unit : 32'(alpha_reg);
      twice_l = 2 * l;
      lum_dist = (twice_l >= unit) ? twice_l - unit : unit - twice_l;
      chroma = ((unit - lum_dist) * s) >> 10;
      hue_mod = h % (2 * span);
      hue_dist = (hue_mod >= span) ? hue_mod - span : span - hue_mod;
      second = (chroma * (span - hue_dist)) / span;
      offset = l - (chroma >> 1);
      r = 0;
      g = 0;
      b = 0;
      case (hsl_pkg::sector_e'(3'(h / span)))
        hsl_pkg::SecRedYellow: begin
          r = chroma;
          g = second;
        end
        hsl_pkg::SecYellowGreen: begin
          r = second;
          g = chroma;
        end
        hsl_pkg::SecGreenCyan: begin
          g = chroma;
          b = second;
        end
        hsl_pkg::SecCyanBlue: begin
          g = second;
          b = chroma;
        end
        hsl_pkg::SecBlueMagenta: begin
          r = second;
          b = chroma;
        end
        default: begin
          r = chroma;
          b = second;
        end
      endcase
      px.red = to_byte(r + offset);
      px.green = to_byte(g + offset);
      px.blue = to_byte(b + offset);
      px.alpha = to_byte(a);
      return px;
    endfunction

    function void note_hue(logic [hsl_pkg::HueW-1:0] hue);
      expected_pixels.push_back(color_for_hue(hue));
    endfunction

    task report_mismatch(string detail);
      $display("MISMATCH at %0t: %s", $realtime, detail);
      mismatches++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %h arrived with no hue pending", got));
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report_mismatch($sformatf("alpha %0d, expected %0d", got.alpha, want.alpha));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [hsl_pkg::HueW-1:0] hue_position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [hsl_pkg::ByteW-1:0] red_o, green_o, blue_o, alpha_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [hsl_pkg::UnitW-1:0] cfg_data_i = '0;

  bit quiet = 1'b1;
  int unsigned stalled_cycles = 0;
  pixel_scoreboard board = new();

  hsl_to_rgba_converter_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .hue_position_i(hue_position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o(red_o),
    .green_o(green_o),
    .blue_o(blue_o),
    .alpha_out_o(alpha_out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) board.note_hue(hue_position_i);
    if (out_valid_o && out_ready_i) board.check_pixel({red_o, green_o, blue_o, alpha_out_o});
    if (cfg_valid_i && cfg_ready_o) board.write_register(cfg_index_i, cfg_data_i);
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task send_hue(input logic [hsl_pkg::HueW-1:0] hue);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    hue_position_i <= hue;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task write_beat(input logic [1:0] index, input logic [hsl_pkg::UnitW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task apply_settings(input logic [hsl_pkg::UnitW-1:0] sat,
                      input logic [hsl_pkg::UnitW-1:0] lum,
                      input logic [hsl_pkg::UnitW-1:0] alp, input bit stray);
    wait_idle();
    write_beat(hsl_pkg::CfgSaturation, sat);
    write_beat(hsl_pkg::CfgLuminance, lum);
    write_beat(hsl_pkg::CfgAlpha, alp);
    if (stray) write_beat(CfgUnused, 11'($urandom_range(2047)));
    cfg_valid_i <= 1'b0;
    repeat (4) @(negedge clk_i);
  endtask

  function logic [hsl_pkg::UnitW-1:0] pick_unit();
    case ($urandom_range(9))
      0: return '0;
      1: return hsl_pkg::UnitOne;
      2: return 11'($urandom_range(2047, 1025));
      default: return 11'($urandom_range(1024));
    endcase
  endfunction

  function logic [hsl_pkg::HueW-1:0] pick_hue();
    int v;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      v = $urandom_range(23039);
    end else if (roll < 90) begin
      v = $urandom_range(6) * 3840 + $urandom_range(2) - 1;
      if (v < 0) v = 0;
    end else begin
      v = $urandom_range(32767, 23040);
    end
    return v[hsl_pkg::HueW-1:0];
  endfunction

  logic [hsl_pkg::HueW-1:0] directed_hues[16] = '{
    15'd0, 15'd1920, 15'd3839, 15'd3840, 15'd7679, 15'd7680, 15'd11519, 15'd11520,
    15'd15359, 15'd15360, 15'd19199, 15'd19200, 15'd23039, 15'd23040, 15'd26880,
    15'd32767
  };

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings, then out-of-range registers with a dropped index, then zeros.
    foreach (directed_hues[i]) send_hue(directed_hues[i]);
    apply_settings(11'd2047, 11'd700, 11'd2047, 1'b1);
    send_hue(15'd0);
    send_hue(15'd9600);
    send_hue(15'd30000);
    apply_settings('0, '0, '0, 1'b0);
    send_hue(15'd5000);
    send_hue(15'd17000);
    send_hue(15'd23039);
    apply_settings(hsl_pkg::UnitOne, 11'd2047, 11'd1100, 1'b0);
    send_hue(15'd3840);
    send_hue(15'd13440);
    send_hue(15'd21000);

    for (int phase = 0; phase < 10; phase++) begin
      apply_settings(pick_unit(), pick_unit(), pick_unit(), $urandom_range(3) == 0);
      quiet = (phase == 3);
      for (int i = 0; i < 115; i++) begin
        if (i == 57 && phase % 3 == 0) wait_idle();
        send_hue(pick_hue());
      end
    end

    quiet = 1'b1;
    wait_idle();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
